// ----- rtl/mfrf_pkg.sv -----
package mfrf_pkg;

    localparam int ID_RING_DEPTH = 128;
    localparam int WINDOW_DEPTH  = ID_RING_DEPTH;
    localparam int ADDR_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // frame types
    localparam logic [2:0] MSG_CHAT     = 3'd0;
    localparam logic [2:0] MSG_DIRECT   = 3'd1;
    localparam logic [2:0] MSG_GROUP    = 3'd2;
    localparam logic [2:0] MSG_PRESENCE = 3'd3;
    localparam logic [2:0] MSG_TYPING   = 3'd4;
    localparam logic [2:0] MSG_BEACON   = 3'd5;
    localparam logic [2:0] MSG_ACK      = 3'd6;

    // drop codes
    localparam logic [1:0] DROP_NONE = 2'd0;
    localparam logic [1:0] DROP_LEN  = 2'd1;
    localparam logic [1:0] DROP_DUP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_GROUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCRYPTION_ON   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLER_PRESENT = 2'd3;

    typedef struct packed {
        logic [47:0] local_address;
        logic [7:0]  local_group;
        logic        encryption_on;
        logic        handler_present;
    } cfg_t;

    typedef struct packed {
        logic        length_valid;
        logic [2:0]  msg_type;
        logic [31:0] msg_id;
        logic        encrypted_flag;
        logic [7:0]  hops_left;
        logic [47:0] target_address;
        logic [47:0] sender_address;
        logic [7:0]  group_number;
    } item_t;

    typedef struct packed {
        logic start;
        logic search_en;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// ----- rtl/mfrf_ctrl.sv -----
module mfrf_ctrl
    import mfrf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next    = state_reg;
        cmd.start     = 1'b0;
        cmd.search_en = 1'b0;
        cmd.finish    = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.search_en = 1'b1;
                if (status.search_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/mfrf_datapath.sv -----
module mfrf_datapath
    import mfrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         status,
    input  cfg_t                 cfg,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_DEPTH);

    logic [31:0]       seen_mem [WINDOW_DEPTH];
    logic [31:0]       rdata_reg;
    item_t             item_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [FILL_W-1:0] rd_idx_reg;
    logic              cmp_pend_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              check_type;
    logic              need_search;
    logic [FILL_W-1:0] fill_eff;
    logic              record;

    logic       to_me;
    logic       peer_ok;
    logic       reenc;
    logic [1:0] dropped;
    logic       learn_peer;
    logic       deliver;
    logic       send_ack;
    logic       release_pending;
    logic       fwd_req;
    logic       fwd_enc_raw;
    logic       forward;
    logic [7:0] forward_hops;
    logic       forward_encrypted;

    assign check_type  = (item_reg.msg_type != MSG_BEACON) && (item_reg.msg_type != MSG_ACK);
    assign need_search = item_reg.length_valid && check_type;
    assign fill_eff    = need_search ? fill_reg : '0;
    assign record      = cmd.finish && need_search && !hit_reg;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg.length_valid   <= s_tdata[0];
            item_reg.msg_type       <= s_tuser;
            item_reg.msg_id         <= s_tdata[32:1];
            item_reg.encrypted_flag <= s_tdata[33];
            item_reg.hops_left      <= s_tdata[41:34];
            item_reg.target_address <= s_tdata[89:42];
            item_reg.sender_address <= s_tdata[137:90];
            item_reg.group_number   <= s_tdata[145:138];
        end
    end

    // window memory, one read or one write a cycle
    always_ff @(posedge aclk) begin
        if (record) begin
            seen_mem[slot_reg] <= item_reg.msg_id;
        end
        if (cmd.search_en) begin
            rdata_reg <= seen_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    // linear search, compare in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg   <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (cmd.start) begin
            rd_idx_reg   <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (cmd.search_en) begin
            if (rd_idx_reg < fill_eff) begin
                rd_idx_reg   <= rd_idx_reg + 1'b1;
                cmp_pend_reg <= 1'b1;
            end else begin
                cmp_pend_reg <= 1'b0;
            end
            if (cmp_pend_reg && (rdata_reg == item_reg.msg_id)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // ring bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            slot_reg <= '0;
        end else if (record) begin
            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
            if (fill_reg != FULL_FILL) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // decision
    assign to_me   = (item_reg.target_address == cfg.local_address);
    assign peer_ok = (item_reg.sender_address != cfg.local_address);
    assign reenc   = item_reg.encrypted_flag && cfg.encryption_on;

    always_comb begin
        dropped         = DROP_NONE;
        learn_peer      = 1'b0;
        deliver         = 1'b0;
        send_ack        = 1'b0;
        release_pending = 1'b0;
        fwd_req         = 1'b0;
        fwd_enc_raw     = 1'b0;
        if (!item_reg.length_valid) begin
            dropped = DROP_LEN;
        end else if (check_type && hit_reg) begin
            dropped = DROP_DUP;
        end else begin
            unique case (item_reg.msg_type)
                MSG_BEACON: begin
                    learn_peer = peer_ok;
                end
                MSG_ACK: begin
                    release_pending = to_me;
                    fwd_req         = !to_me;
                end
                MSG_CHAT: begin
                    learn_peer  = peer_ok;
                    deliver     = 1'b1;
                    fwd_req     = 1'b1;
                    fwd_enc_raw = reenc;
                end
                MSG_DIRECT: begin
                    learn_peer = to_me && peer_ok;
                    send_ack   = to_me;
                    deliver    = to_me;
                    fwd_req    = !to_me;
                end
                MSG_GROUP: begin
                    learn_peer  = peer_ok;
                    deliver     = (item_reg.group_number == cfg.local_group);
                    fwd_req     = 1'b1;
                    fwd_enc_raw = reenc;
                end
                MSG_PRESENCE: begin
                    learn_peer  = peer_ok;
                    deliver     = cfg.handler_present;
                    fwd_req     = 1'b1;
                    fwd_enc_raw = reenc;
                end
                MSG_TYPING: begin
                    deliver     = to_me && cfg.handler_present;
                    fwd_req     = !to_me;
                    fwd_enc_raw = !to_me && reenc;
                end
                default: begin
                end
            endcase
        end
    end

    assign forward           = fwd_req && (item_reg.hops_left >= 8'd2);
    assign forward_hops      = forward ? item_reg.hops_left - 8'd1 : 8'd0;
    assign forward_encrypted = forward && fwd_enc_raw;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {forward_encrypted, forward_hops, forward, release_pending,
                             send_ack, deliver, learn_peer, dropped};
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = out_data_reg;
    assign status.search_done = (rd_idx_reg >= fill_eff) && !cmp_pend_reg;
    assign status.out_free    = !out_valid_reg || m_tready;

`ifndef SYNTHESIS
    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < FULL_FILL) |-> (slot_reg == fill_reg[ADDR_W-1:0]))
        else $error("write slot out of step with fill count");

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (record && (fill_reg != FULL_FILL)) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance on record");

    a_read_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_en |-> (rd_idx_reg <= fill_eff))
        else $error("search read beyond filled entries");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != DROP_NONE)) |-> (m_tdata[15:2] == '0))
        else $error("dropped frame carries actions");

    a_fwd_hops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[14:7] != 8'd0))
        else $error("forward with zero hops");
`endif

endmodule

// ----- rtl/mesh_frame_receive_filter.sv -----
// mesh frame receive filter: takes one received frame header per s_ word and returns one
// decision word on m_. bad-length frames are dropped at once; every type other than beacon
// or ack is looked up in a ring of the last 128 message ids, dropped as a duplicate if
// found and recorded otherwise (oldest id overwritten once the ring is full). a searched
// frame walks the linear search through the single-port id memory, one entry a cycle,
// over the filled entries only; bad-length, beacon and ack frames, and any frame while
// the ring is empty, skip the search. the time an item occupies is set by that search
// plus any time the previous decision still waits on m_. the next frame is taken once
// the decision is in the result register. one item is in flight at a time; the result
// register lets the next frame be taken while a decision still waits on m_. the id
// memory has no reset and needs no clearing pass: only entries already written are
// searched. configuration writes take effect at once and are meant to be made while
// the block is idle
module mesh_frame_receive_filter
    import mfrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // frame header in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // length_valid[0], msg_id[32:1], encrypted_flag[33], hops_left[41:34],
    // target_address[89:42], sender_address[137:90], group_number[145:138], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // msg_type[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // decision out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dropped[1:0], learn_peer[2], deliver[3], send_ack[4], release_pending[5],
    // forward[6], forward_hops[14:7], forward_encrypted[15]
    output logic [M_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t         cfg_reg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // configuration is always writable
    assign cfg_ready = 1'b1;

    // configuration registers, cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LOCAL_ADDRESS:   cfg_reg.local_address   <= cfg_data;
                REG_LOCAL_GROUP:     cfg_reg.local_group     <= cfg_data[7:0];
                REG_ENCRYPTION_ON:   cfg_reg.encryption_on   <= cfg_data[0];
                REG_HANDLER_PRESENT: cfg_reg.handler_present <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: idle, search, decide
    mfrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // header capture, id window, decision and result register
    mfrf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
